### src/scfp_pkg.sv
// Shared types and constants of the servo and motor command frame parser.
package scfp_pkg;

	localparam logic [7:0]  HDR_SERVO   = 8'hA5;
	localparam logic [7:0]  HDR_MOTOR   = 8'hB5;
	localparam logic [7:0]  TAIL_SERVO  = 8'h5A;
	localparam logic [7:0]  TAIL_MOTOR  = 8'h5B;
	localparam logic [15:0] LIMIT_RESET = 16'd270;

	localparam int unsigned OUT_BITS  = 82;
	localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

	typedef enum logic [1:0] {
		ST_SERVO_STORED   = 2'd0,
		ST_SERVO_REJECTED = 2'd1,
		ST_MOTOR_SET      = 2'd2,
		ST_DROPPED        = 2'd3
	} status_t;

	typedef struct packed {
		logic        done;
		logic [7:0]  hdr;
		logic [7:0]  id;
		logic [15:0] value;
		logic [7:0]  tail;
	} frame_t;

endpackage

### src/scfp_framer.sv
// Input register, byte counter and frame byte store of the frame parser.
module scfp_framer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,
	input  logic           advance,
	output scfp_pkg::frame_t frame
);
	import scfp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [2:0] count_q;
	logic [7:0] hdr_q;
	logic [7:0] id_q;
	logic [7:0] lo_q;
	logic [7:0] hi_q;
	logic       fire;

	assign fire     = valid_s1 & advance;
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
		end else if (fire) begin
			unique case (count_q)
				3'd0: begin
					if (byte_s1 == HDR_SERVO || byte_s1 == HDR_MOTOR) begin
						count_q <= 3'd1;
					end
				end
				3'd1, 3'd2, 3'd3: count_q <= count_q + 3'd1;
				default: count_q <= 3'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			unique case (count_q)
				3'd0: hdr_q <= byte_s1;
				3'd1: id_q  <= byte_s1;
				3'd2: lo_q  <= byte_s1;
				3'd3: hi_q  <= byte_s1;
				default: ;
			endcase
		end
	end

	always_comb begin
		frame.done  = fire && (count_q == 3'd4);
		frame.hdr   = hdr_q;
		frame.id    = id_q;
		frame.value = {hi_q, lo_q};
		frame.tail  = byte_s1;
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("byte count out of range");
	a_count_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done |=> count_q == 3'd0)
		else $error("count did not wrap after fifth byte");
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(count_q))
		else $error("count moved without a beat");
`endif

endmodule

### src/scfp_judge.sv
// Frame check, stored servo and motor values, and result register.
module scfp_judge #(
	parameter int unsigned NUM_SERVOS = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [15:0]      cfg_wr_data,
	input  scfp_pkg::frame_t frame,
	output logic             advance,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [scfp_pkg::OUT_BYTES*8-1:0] m_tdata
);
	import scfp_pkg::*;

	logic [15:0]        limit_q;
	logic [15:0]        angles_q [NUM_SERVOS];
	logic [7:0]         servo_id_q;
	logic [7:0]         motor_id_q;
	logic signed [15:0] motor_target_q;
	status_t            status_s2;
	logic               valid_s2;
	logic               servo_hit;
	logic               motor_hit;
	logic               servo_ok;
	status_t            status_d;
	logic [15:0]        angle_out [3];

	assign advance   = ~valid_s2 | m_tready;
	assign servo_hit = (frame.hdr == HDR_SERVO) && (frame.tail == TAIL_SERVO);
	assign motor_hit = (frame.hdr == HDR_MOTOR) && (frame.tail == TAIL_MOTOR);
	assign servo_ok  = (frame.id != 8'd0) && (frame.id <= 8'(NUM_SERVOS)) &&
		(frame.value <= limit_q);

	always_comb begin
		priority if (servo_hit) begin
			status_d = servo_ok ? ST_SERVO_STORED : ST_SERVO_REJECTED;
		end else if (motor_hit) begin
			status_d = ST_MOTOR_SET;
		end else begin
			status_d = ST_DROPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVOS; i++) begin
				angles_q[i] <= 16'd0;
			end
			servo_id_q     <= 8'd0;
			motor_id_q     <= 8'd0;
			motor_target_q <= 16'sd0;
		end else if (frame.done) begin
			if (servo_hit) begin
				servo_id_q <= frame.id;
				for (int i = 0; i < NUM_SERVOS; i++) begin
					if (servo_ok && frame.id == 8'(i + 1)) begin
						angles_q[i] <= frame.value;
					end
				end
			end
			if (motor_hit) begin
				motor_id_q     <= frame.id;
				motor_target_q <= signed'(frame.value);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (frame.done) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.done) begin
			status_s2 <= status_d;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_angle
		if (k < NUM_SERVOS) begin : g_used
			assign angle_out[k] = angles_q[k];
		end else begin : g_none
			assign angle_out[k] = 16'd0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(OUT_BYTES * 8 - OUT_BITS)'(0), motor_target_q, motor_id_q,
		angle_out[2], angle_out[1], angle_out[0], servo_id_q, status_s2};

`ifndef SYNTHESIS
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done |=> m_tvalid)
		else $error("frame end gave no result beat");
	a_done_advance: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done |-> advance)
		else $error("frame judged while result held");
	a_motor_take: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done && motor_hit |=> motor_target_q == signed'($past(frame.value)))
		else $error("motor target not taken");
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!frame.done |=> $stable(motor_target_q) && $stable(servo_id_q) &&
		$stable(motor_id_q))
		else $error("stored values moved outside a frame end");
`endif

endmodule

### src/servo_motor_command_frame_parser.sv
// Top level of the servo and motor command frame parser.
//
//   channel  dir  fields (low bit up)
//   s_*      in   tdata: rx_byte[7:0]
//   m_*      out  tdata: frame_status[1:0], servo_id, servo_angle_one, servo_angle_two,
//                        servo_angle_three, motor_id, motor_target, zero fill to 88 bits
//   cfg_*    in   servo_angle_limit
//
// One byte per cycle while no held result beat stalls the input; the frame's fifth input
// beat passes the input register and then the result register, which holds its result beat.
// Reset clears the byte count, stored angles, ids and target; the limit returns to 270.
// A held result beat stalls the input register, and tready falls only while both are full.
module servo_motor_command_frame_parser #(
	parameter int unsigned NUM_SERVOS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// frame_status, servo_id, servo_angle_one..three, motor_id, motor_target, zero fill
	output logic [scfp_pkg::OUT_BYTES*8-1:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import scfp_pkg::*;

	frame_t frame;
	logic   advance;

	scfp_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.frame    (frame)
	);

	scfp_judge #(
		.NUM_SERVOS (NUM_SERVOS)
	) u_judge (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.frame       (frame),
		.advance     (advance),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule
